[design/sitda_pkg.sv]
// sitda_pkg: shared types and constants for the signed integer to decimal ascii block
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int DIGITS      = 10;
    localparam int DIG_IDX_W   = 4;
    localparam int STEP_W      = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    // classified item handed from the front part to the back part
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } sitda_item_t;

    typedef logic [DIGITS-1:0][DIGIT_W-1:0] sitda_bcd_t;

endpackage

`default_nettype wire

[design/sitda_in_if.sv]
// sitda_in_if: valid/ready channel carrying one signed 32-bit value
// depends on sitda_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sitda_in_if
    import sitda_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

[design/sitda_out_if.sv]
// sitda_out_if: valid/ready channel carrying one ascii character and its last flag
// depends on sitda_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sitda_out_if
    import sitda_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

[design/sitda_front.sv]
// sitda_front: accepts input values, splits them into sign and unsigned magnitude
// depends on sitda_pkg and sitda_in_if
`timescale 1ns / 1ps
`default_nettype none

module sitda_front
    import sitda_pkg::*;
(
    sitda_in_if.sink     din,
    input  wire logic    queue_full,
    output sitda_item_t  push_item,
    output logic         push
);

    logic [VALUE_W-1:0] raw;

    always_comb
    begin
        raw           = din.value;
        push_item.neg = raw[VALUE_W-1];
        // two's complement magnitude; the most negative value maps to 2^31 unsigned
        push_item.mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    end

    assign din.ready = !queue_full;
    assign push      = din.valid && !queue_full;

endmodule

`default_nettype wire

[design/sitda_queue.sv]
// sitda_queue: short first-in first-out queue of classified items between front and back
// depends on sitda_pkg
`timescale 1ns / 1ps
`default_nettype none

module sitda_queue
    import sitda_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH   // 2 to 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire sitda_item_t  push_item,
    output logic              full,
    input  wire logic         pop,
    output sitda_item_t       head_item,
    output logic              head_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    sitda_item_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[design/sitda_back.sv]
// sitda_back: serial binary to bcd conversion, then emits the characters through an output register
// depends on sitda_pkg and sitda_out_if
`timescale 1ns / 1ps
`default_nettype none

module sitda_back
    import sitda_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         head_valid,
    input  wire sitda_item_t  head_item,
    output logic              pop,
    sitda_out_if.source       dout
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SIZE = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(VALUE_W - 1);
    localparam logic [DIGIT_W-1:0]   ADJ_MIN   = 4'd5;
    localparam logic [DIGIT_W-1:0]   ADJ_ADD   = 4'd3;

    logic [1:0]           state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    sitda_bcd_t           bcd_reg, bcd_next;
    logic                 minus_reg, minus_next;
    logic [DIG_IDX_W-1:0] ptr_reg, ptr_next;

    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    sitda_bcd_t                  adj;
    logic [DIGITS*DIGIT_W-1:0]   adj_bits;
    logic [DIG_IDX_W-1:0]        lead;
    logic                        slot_free;
    logic                        emit;

    // add-3 correction on every digit, then shift in the next magnitude bit
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= ADJ_MIN) ? bcd_reg[i] + ADJ_ADD : bcd_reg[i];
        end
    end

    assign adj_bits = adj;

    // highest nonzero digit, digit zero when the value is zero
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i] != '0)
            begin
                lead = DIG_IDX_W'(i);
            end
        end
    end

    assign slot_free = !out_valid_reg || dout.ready;
    assign emit      = (state_reg == S_EMIT) && slot_free;
    assign pop       = (state_reg == S_IDLE) && head_valid;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        minus_next     = minus_reg;
        ptr_next       = ptr_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !dout.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    mag_next   = head_item.mag;
                    minus_next = head_item.neg;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                bcd_next  = {adj_bits[DIGITS*DIGIT_W-2:0], mag_reg[VALUE_W-1]};
                mag_next  = {mag_reg[VALUE_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                ptr_next   = lead;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (minus_reg)
                    begin
                        char_next  = CHAR_MINUS;
                        last_next  = 1'b0;
                        minus_next = 1'b0;
                    end
                    else
                    begin
                        char_next = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_reg[ptr_reg]};
                        last_next = (ptr_reg == '0);
                        if (ptr_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            minus_reg     <= 1'b0;
            ptr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            minus_reg     <= minus_next;
            ptr_reg       <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        if (emit)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.char_code = char_reg;
    assign dout.last_char = last_reg;

endmodule

`default_nettype wire

[design/signed_int_to_decimal_ascii.sv]
// signed_int_to_decimal_ascii: top level, signed 32-bit value in, decimal ascii characters out
// each value passes through the queue and the idle, conv, size and emit states into the output register
// the back part converts one value at a time with a 32-step bcd shift loop into 1 to 11 characters,
// taking the next only after the last; characters leave at one per cycle while the sink keeps ready high
// reset: rst_n asynchronous, active low, empties the queue and the output register
// depends on sitda_pkg, sitda_in_if, sitda_out_if, sitda_front, sitda_queue, sitda_back
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sitda_in_if.sink    din,
    sitda_out_if.source dout
);

    sitda_item_t push_item;
    sitda_item_t head_item;
    logic        push;
    logic        queue_full;
    logic        pop;
    logic        head_valid;

    sitda_front u_front (
        .din        (din),
        .queue_full (queue_full),
        .push_item  (push_item),
        .push       (push)
    );

    sitda_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid)
    );

    sitda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .dout       (dout)
    );

endmodule

`default_nettype wire
